// ----- rtl/core/deq_pkg.sv -----
`timescale 1ns / 1ps

package deq_pkg;

  // Default configuration of the queue.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new request
    logic exec;  // perform the memory access and pointer update
  } cmd_t;

endpackage

// ----- rtl/core/double_ended_queue.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// request  | in        | start_i && !busy_o   | req_type_i, push_value_i
// result   | out       | done_o (one cycle)   | read_value_o, status_o, count_after_o,
//          |           |                      | is_empty_o, is_full_o
//
// A request is captured when it is accepted and performs its memory access in the next;
// its result strobes on done_o in the cycle after that.
// A new request is accepted in the cycle its predecessor's result is shown; no
// request is taken while busy_o is high during the memory access.
// Reset clears the front pointer and word count; the store needs no clearing
// pass because only written entries are ever read.
// The result side cannot stall; busy_o is the only back pressure on requests.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [VALUE_W-1:0]  push_value_i,
  output logic                done_o,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [COUNT_W-1:0]  count_after_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  cmd_t cmd;

  // Sequencing of each request.
  deq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Ring store, pointers and result registers.
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .count_after_o (count_after_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

// ----- rtl/core/deq_ctrl.sv -----
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. A new request may be taken while the previous result is shown.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = start_i ? ST_ACCESS : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    busy_o      = 1'b0;
    done_o      = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_ACCESS: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      ST_DONE: begin
        done_o     = 1'b1;
        cmd_o.load = start_i;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/deq_datapath.sv -----
`timescale 1ns / 1ps

module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [VALUE_W-1:0]  push_value_i,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [COUNT_W-1:0]  count_after_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  // Captured request.
  logic [REQ_W-1:0]      req_q;
  logic [DATA_WIDTH-1:0] value_q;

  // Ring pointers.
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Result state.
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [DATA_WIDTH-1:0] rd_data_q;

  // Ring store.
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [DATA_WIDTH+VALUE_W-1:0] push_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
  logic [CNT_W+COUNT_W-1:0]      cnt_ext;

  logic             empty, full;
  logic [IDX_W-1:0] front_inc, front_dec, tail_idx, back_idx;
  logic [SUM_W-1:0] tail_sum;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;

  // Fit the push word to the stored width.
  assign push_ext = {{DATA_WIDTH{1'b0}}, push_value_i};

  // Capture the request when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      value_q <= push_ext[DATA_WIDTH-1:0];
    end
  end

  // Ring arithmetic. The tail sum stays below twice the depth, so one
  // compare and subtract brings it back into range.
  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == CNT_FULL);
  assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
  assign tail_sum  = SUM_W'(front_q) + SUM_W'(cnt_q);
  assign tail_idx  = (tail_sum >= SUM_DEPTH) ? IDX_W'(tail_sum - SUM_DEPTH)
                                             : IDX_W'(tail_sum);
  assign back_idx  = (tail_idx == '0) ? IDX_LAST : tail_idx - 1'b1;

  // Decode the request into a memory access and a pointer update.
  always_comb begin
    front_d  = front_q;
    cnt_d    = cnt_q;
    status_d = STATUS_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = tail_idx;
    raddr    = front_q;
    unique case (req_q) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (req_q == REQ_PUSH_FRONT) begin
            waddr   = front_dec;
            front_d = front_dec;
          end
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
          if (req_q == REQ_POP_FRONT) begin
            front_d = front_inc;
            cnt_d   = cnt_q - 1'b1;
          end
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
          raddr   = back_idx;
          if (req_q == REQ_POP_BACK) cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  // Pointer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      cnt_q    <= '0;
      status_q <= STATUS_OK;
      rd_ok_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  // Ring store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem_q[waddr] <= value_q;
    if (cmd_i.exec && re) rd_data_q <= mem_q[raddr];
  end

  // Result fields. The count and flags already reflect this request.
  assign rd_ext        = {{VALUE_W{1'b0}}, rd_data_q};
  assign cnt_ext       = {{COUNT_W{1'b0}}, cnt_q};
  assign read_value_o  = rd_ok_q ? rd_ext[VALUE_W-1:0] : '0;
  assign status_o      = status_q;
  assign count_after_o = cnt_ext[COUNT_W-1:0];
  assign is_empty_o    = empty;
  assign is_full_o     = full;

endmodule

// ----- rtl/core/deq_checker.sv -----
`timescale 1ns / 1ps

module deq_props
  import deq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_i,
  input logic                done_i,
  input logic [VALUE_W-1:0]  read_value_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [COUNT_W-1:0]  count_after_i,
  input logic                is_empty_i,
  input logic                is_full_i
);

  // An accepted request occupies the block in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("request accepted but block not busy");

  // Every accepted request yields its result once its access state has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |-> ##2 done_i)
    else $error("result missing after request");

  // A result is only shown right after a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy_i))
    else $error("result without a preceding access");

  // An empty error returns no word and leaves the queue empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && status_i == STATUS_EMPTY |->
      read_value_i == '0 && is_empty_i && count_after_i == '0)
    else $error("empty error with data or nonempty queue");

  // A full error leaves the queue full and returns no word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && status_i == STATUS_FULL |-> is_full_i && !is_empty_i && read_value_i == '0)
    else $error("full error on a queue that is not full");

endmodule

bind double_ended_queue deq_props u_deq_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .done_i        (done_o),
  .read_value_i  (read_value_o),
  .status_i      (status_o),
  .count_after_i (count_after_o),
  .is_empty_i    (is_empty_o),
  .is_full_i     (is_full_o)
);
